>>> sv/mbfn_pkg.sv
// Shared types, register indexes and line-rotation helpers for the mask boundary block.
`default_nettype none

package mbfn_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_INNER_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 11'd640;

    // Result coordinates
    localparam int COORD_W = 12;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Line store selector, three lines in rotation
    typedef logic [1:0] line_sel_t;

    localparam line_sel_t LINE_0 = 2'd0;
    localparam line_sel_t LINE_1 = 2'd1;
    localparam line_sel_t LINE_2 = 2'd2;

    // Control carried with one pixel from the read stage to the judge stage
    typedef struct packed {
        logic      inner;
        logic      have1;
        logic      have2;
        logic      first_col;
        logic      last_col;
        logic      right_ok;
        line_sel_t up1;
        line_sel_t up2;
    } judge_ctrl_t;

    // Fold the unused selector code onto line 0
    function automatic line_sel_t line_fold(input line_sel_t v);
        line_sel_t res;
        case (v)
            LINE_1:  res = LINE_1;
            LINE_2:  res = LINE_2;
            default: res = LINE_0;
        endcase
        return res;
    endfunction

    // Line written after the next row change
    function automatic line_sel_t line_advance(input line_sel_t v);
        line_sel_t res;
        case (line_fold(v))
            LINE_0:  res = LINE_1;
            LINE_1:  res = LINE_2;
            default: res = LINE_0;
        endcase
        return res;
    endfunction

    // Line holding the row one above the current one
    function automatic line_sel_t line_above1(input line_sel_t cur);
        line_sel_t res;
        case (cur)
            LINE_1:  res = LINE_0;
            LINE_2:  res = LINE_1;
            default: res = LINE_2;
        endcase
        return res;
    endfunction

    // Line holding the row two above the current one
    function automatic line_sel_t line_above2(input line_sel_t cur);
        line_sel_t res;
        case (cur)
            LINE_1:  res = LINE_2;
            LINE_2:  res = LINE_0;
            default: res = LINE_1;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/mask_boundary_four_neighbor.sv
// Streaming 4-neighbor boundary point extractor over a binary mask, with three line stores.
//
// Usage: pixels of a binary mask enter on in_valid/in_ready in raster order, one per
// beat, start_of_frame high on the first pixel of each frame. After the last frame row
// the source sends two more rows of zeros so the bottom border is judged. Each pixel
// (c, r) judges point (c, r-1) and gives at most one result beat on out_valid/out_ready
// (point_x, point_y, last); last is high on every result.
// A result goes from the judge stage register to the output register. Throughput: one
// pixel per cycle while no result is blocked at the output. The three line stores sit in
// one memory of 3-bit words, one word per column, read at columns c and c+1 and written
// at column c in the accept cycle; the left neighbor is the previous pixel's center bit.
// Configuration (inner_mode, row_width) is written on cfg_valid/cfg_ready while the
// stream is idle; cfg_ready is always high.
// Reset clears row, column, line rotation and the pipeline; inner_mode returns to 1 and
// row_width to 640. Line store content is not cleared: rows above the frame read as
// zero through the row count.
// When out_ready is low the result holds in the output register; pixels are still
// taken while the judge stage can drop its pixel or move it on, so at most two pixels
// wait before in_ready falls.
`default_nettype none

module mask_boundary_four_neighbor #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mbfn_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [mbfn_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 pixel,
    input  wire                                 start_of_frame,

    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [mbfn_pkg::COORD_W-1:0] point_x,
    output logic signed [mbfn_pkg::COORD_W-1:0] point_y,
    output logic                                last
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int FW = (CW > mbfn_pkg::CFG_DATA_W) ? CW : mbfn_pkg::CFG_DATA_W;

    // Configuration registers
    logic                            inner_mode_reg;
    logic [mbfn_pkg::CFG_DATA_W-1:0] row_width_reg;

    // Scan position
    logic [CW-1:0]       column_reg, column_next;
    logic [RW-1:0]       row_reg, row_next;
    mbfn_pkg::line_sel_t newest_line_reg, newest_line_next;

    // Line store and its registered read ports
    logic [2:0]    line_mem [MAX_WIDTH];
    logic [2:0]    rd_a_reg, rd_b_reg;
    logic [AW-1:0] addr_a, addr_b;

    // Judge stage
    logic                  s1_valid_reg;
    logic                  s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [CW-1:0]         s1_width_reg;
    mbfn_pkg::coord_t      s1_y_reg;
    mbfn_pkg::judge_ctrl_t s1_ctrl_reg, s0_ctrl;
    logic                  prev_center_reg;

    // Output register
    logic             out_valid_reg;
    mbfn_pkg::coord_t out_x_reg, out_y_reg;

    logic                in_accept;
    logic [FW-1:0]       fw_ext;
    logic [CW-1:0]       width_used;
    logic [CW-1:0]       col_s, col_c, col_plus;
    logic [RW-1:0]       row_s, row_c;
    mbfn_pkg::line_sel_t line_s, line_c, cur_line;

    logic             center_raw, m_bit, u_bit, l_bit, r_bit, s1_hit, s1_free, s1_leave;
    mbfn_pkg::coord_t s1_x;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    // Clamp the configured width into the supported range
    always_comb
    begin
        fw_ext = FW'(row_width_reg);
        if (fw_ext < FW'(2))
        begin
            width_used = CW'(2);
        end
        else if (fw_ext > FW'(MAX_WIDTH))
        begin
            width_used = CW'(MAX_WIDTH);
        end
        else
        begin
            width_used = CW'(fw_ext);
        end
    end

    // Locate the incoming pixel and plan the position after it
    always_comb
    begin
        col_s  = start_of_frame ? '0 : column_reg;
        row_s  = start_of_frame ? '0 : row_reg;
        line_s = newest_line_reg;

        if (col_s >= width_used)
        begin
            col_c  = '0;
            row_c  = (row_s < RW'(MAX_HEIGHT + 1)) ? row_s + 1'b1 : row_s;
            line_c = mbfn_pkg::line_advance(line_s);
        end
        else
        begin
            col_c  = col_s;
            row_c  = row_s;
            line_c = line_s;
        end

        cur_line = mbfn_pkg::line_fold(line_c);
        col_plus = col_c + 1'b1;

        s0_ctrl.inner     = inner_mode_reg;
        s0_ctrl.have1     = (row_c != '0);
        s0_ctrl.have2     = (row_c >= RW'(2));
        s0_ctrl.first_col = (col_c == '0);
        s0_ctrl.last_col  = (col_plus == width_used);
        s0_ctrl.right_ok  = (col_plus < width_used);
        s0_ctrl.up1       = mbfn_pkg::line_above1(cur_line);
        s0_ctrl.up2       = mbfn_pkg::line_above2(cur_line);

        addr_a = col_c[AW-1:0];
        addr_b = s0_ctrl.right_ok ? col_plus[AW-1:0] : col_c[AW-1:0];

        if (col_plus >= width_used)
        begin
            column_next      = '0;
            row_next         = (row_c < RW'(MAX_HEIGHT + 1)) ? row_c + 1'b1 : row_c;
            newest_line_next = mbfn_pkg::line_advance(line_c);
        end
        else
        begin
            column_next      = col_plus;
            row_next         = row_c;
            newest_line_next = line_c;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_mode_reg <= 1'b1;
            row_width_reg  <= mbfn_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mbfn_pkg::REG_INNER_MODE: inner_mode_reg <= cfg_data[0];
                mbfn_pkg::REG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Advance the scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            row_reg         <= '0;
            newest_line_reg <= mbfn_pkg::LINE_0;
        end
        else if (in_accept)
        begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            newest_line_reg <= newest_line_next;
        end
    end

    // Write the pixel into the current line, read the rows above
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_mem[addr_a][cur_line] <= pixel;
            rd_a_reg                   <= line_mem[addr_a];
            rd_b_reg                   <= line_mem[addr_b];
        end
    end

    // Load the judge stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_c;
            s1_width_reg <= width_used;
            s1_y_reg     <= mbfn_pkg::coord_t'(row_c) - mbfn_pkg::coord_t'(1);
            s1_ctrl_reg  <= s0_ctrl;
        end
    end

    // Judge the point one row above the pixel
    always_comb
    begin
        center_raw = rd_a_reg[s1_ctrl_reg.up1];
        m_bit      = s1_ctrl_reg.have1 && center_raw;
        u_bit      = s1_ctrl_reg.have2 && rd_a_reg[s1_ctrl_reg.up2];
        l_bit      = s1_ctrl_reg.have1 && !s1_ctrl_reg.first_col && prev_center_reg;
        r_bit      = s1_ctrl_reg.have1 && s1_ctrl_reg.right_ok && rd_b_reg[s1_ctrl_reg.up1];

        s1_x = mbfn_pkg::coord_t'(s1_col_reg);
        if (s1_ctrl_reg.inner)
        begin
            s1_hit = m_bit && !(l_bit && r_bit && u_bit && s1_pixel_reg);
        end
        else
        begin
            s1_hit = (m_bit && (s1_ctrl_reg.first_col || s1_ctrl_reg.last_col))
                  || (!m_bit && (l_bit || r_bit || u_bit || s1_pixel_reg));
            if (m_bit && s1_ctrl_reg.first_col)
            begin
                s1_x = {mbfn_pkg::COORD_W{1'b1}};
            end
            else if (m_bit)
            begin
                s1_x = mbfn_pkg::coord_t'(s1_width_reg);
            end
        end

        s1_free  = !s1_valid_reg || !s1_hit || !out_valid_reg || out_ready;
        s1_leave = s1_valid_reg && s1_free;
    end

    assign in_ready = s1_free;

    // Track judge stage occupancy and the left neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            prev_center_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_leave)
            begin
                prev_center_reg <= center_raw;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_leave && s1_hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_hit)
        begin
            out_x_reg <= s1_x;
            out_y_reg <= s1_y_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = out_x_reg;
    assign point_y   = out_y_reg;
    assign last      = out_valid_reg;

    // An accepted pixel always lands in the judge stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted pixel missing from judge stage");

    // Input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // Line rotation never reaches the unused selector code
    a_line_code: assert property (@(posedge clk) disable iff (!rst_n)
        newest_line_reg != 2'd3)
        else $error("line selector out of rotation");

    // Scan column stays within the supported width
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= CW'(MAX_WIDTH))
        else $error("scan column beyond supported width");

    // A result never reports a row above the first outer row
    a_point_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_y >= mbfn_pkg::coord_t'(-1)))
        else $error("result row below minus one");

endmodule

`default_nettype wire

>>> dv/mask_boundary_point_check.sv
// Channel monitor, boundary point predictor and result checker for the mask boundary block.
`timescale 1ns / 100ps

module mask_boundary_point_check #(
    parameter int MAX_W = 1024,
    parameter int MAX_H = 1024
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 cfg_valid,
    input  wire                                 cfg_ready,
    input  wire  [mbfn_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [mbfn_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire                                 in_valid,
    input  wire                                 in_ready,
    input  wire                                 pixel,
    input  wire                                 start_of_frame,

    input  wire                                 out_valid,
    input  wire                                 out_ready,
    input  wire  signed [mbfn_pkg::COORD_W-1:0] point_x,
    input  wire  signed [mbfn_pkg::COORD_W-1:0] point_y,
    input  wire                                 last,

    output int                                  mismatch_count,
    output int                                  pending_points
);

    typedef struct packed {
        mbfn_pkg::coord_t x;
        mbfn_pkg::coord_t y;
        logic             last;
    } boundary_point_t;

    localparam int PRINT_LIMIT = 100;

    // Register copies
    logic                            inner_mode = 1'b1;
    logic [mbfn_pkg::CFG_DATA_W-1:0] width_reg  = mbfn_pkg::ROW_WIDTH_RESET;

    // Scan position and the three rotating mask lines
    int unsigned scan_col    = 0;
    int unsigned scan_row    = 0;
    int unsigned newest_line = 0;
    bit          mask_rows [3][MAX_W];

    boundary_point_t expected_points[$];
    boundary_point_t want;
    int              fail_total = 0;

    assign mismatch_count = fail_total;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
        fail_total++;
    endtask

    // End the current row and rotate the line stores
    task automatic advance_row();
        scan_col = 0;
        if (scan_row < MAX_H + 1)
            scan_row++;
        newest_line = (newest_line >= 2) ? 0 : newest_line + 1;
    endtask

    task automatic add_point(input int x, input int y);
        boundary_point_t pt;
        pt.x    = mbfn_pkg::coord_t'(x);
        pt.y    = mbfn_pkg::coord_t'(y);
        pt.last = 1'b0;
        expected_points.insert(expected_points.size(), pt);
    endtask

    // Judge point (c, row - 1) as pixel (c, row) arrives
    task automatic judge_pixel(input logic p, input logic sof);
        int unsigned w, c, cur, up1, up2, queued_ahead;
        bit          m, u, l, r;
        int          y;
        w = (width_reg < 2) ? 2 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        if (sof)
        begin
            scan_col = 0;
            scan_row = 0;
        end
        if (scan_col >= w)
            advance_row();

        c   = scan_col;
        cur = newest_line;
        up1 = (cur + 2) % 3;
        up2 = (cur + 1) % 3;
        m = (scan_row >= 1) && mask_rows[up1][c];
        u = (scan_row >= 2) && mask_rows[up2][c];
        l = (scan_row >= 1) && (c > 0) && mask_rows[up1][c - 1];
        r = (scan_row >= 1) && (c + 1 < w) && mask_rows[up1][c + 1];
        mask_rows[cur][c] = p;

        y = int'(scan_row) - 1;
        queued_ahead = expected_points.size();
        if (inner_mode)
        begin
            if (m && !(l && r && u && p))
                add_point(c, y);
        end
        else
        begin
            if (c == 0 && m)
                add_point(-1, y);
            if (!m && (l || r || u || p))
                add_point(c, y);
            if (c == w - 1 && m)
                add_point(w, y);
        end
        if (expected_points.size() > queued_ahead)
            expected_points[expected_points.size() - 1].last = 1'b1;

        scan_col++;
        if (scan_col >= w)
            advance_row();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_mode  = 1'b1;
            width_reg   = mbfn_pkg::ROW_WIDTH_RESET;
            scan_col    = 0;
            scan_row    = 0;
            newest_line = 0;
            foreach (mask_rows[i, j])
                mask_rows[i][j] = 1'b0;
            expected_points.delete();
            pending_points <= 0;
        end
        else
        begin
            // Take register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbfn_pkg::REG_INNER_MODE: inner_mode = cfg_data[0];
                    mbfn_pkg::REG_ROW_WIDTH:  width_reg  = cfg_data;
                    default: ;
                endcase
            end

            // Predict the points for each accepted pixel beat
            if (in_valid && in_ready)
                judge_pixel(pixel, start_of_frame);

            // Compare each result beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("unexpected point (%0d, %0d) last %0b",
                                              point_x, point_y, last));
                else
                begin
                    want = expected_points.pop_front();
                    if (point_x !== want.x)
                        report_mismatch($sformatf("point_x %0d, expected %0d",
                                                  point_x, want.x));
                    if (point_y !== want.y)
                        report_mismatch($sformatf("point_y %0d, expected %0d",
                                                  point_y, want.y));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b at (%0d, %0d)",
                                                  last, want.last, want.x, want.y));
                end
            end

            pending_points <= expected_points.size();
        end
    end

endmodule

>>> dv/mask_boundary_four_neighbor_test.sv
// Top of the mask boundary testbench: clock, reset, mask frame stimulus and verdict.
`timescale 1ns / 100ps

module mask_boundary_four_neighbor_test;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int IDLE_PCT       = 23;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_PIXELS   = 1550;

    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             cfg_valid      = 1'b0;
    logic [mbfn_pkg::CFG_INDEX_W-1:0] cfg_index      = mbfn_pkg::REG_INNER_MODE;
    logic [mbfn_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                             in_valid       = 1'b0;
    logic                             pixel          = 1'b0;
    logic                             start_of_frame = 1'b0;
    logic                             out_ready      = 1'b0;

    logic                             cfg_ready;
    logic                             in_ready;
    logic                             out_valid;
    mbfn_pkg::coord_t                 point_x;
    mbfn_pkg::coord_t                 point_y;
    logic                             last;

    int mismatch_count;
    int pending_points;

    // Stimulus bookkeeping
    bit   steady      = 1'b0;
    logic cur_mode    = 1'b1;
    int   cur_w       = 640;
    int   pixels_sent = 0;
    int   quiet_cycles = 0;

    always #1 clk = ~clk;

    mask_boundary_four_neighbor #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .last           (last)
    );

    mask_boundary_point_check #(
        .MAX_W (MAX_WIDTH),
        .MAX_H (MAX_HEIGHT)
    ) i_point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .last           (last),
        .mismatch_count (mismatch_count),
        .pending_points (pending_points)
    );

    // Stall the result side at random, except in the steady stretch
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("mask_boundary_four_neighbor_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Send one pixel beat, idling at random ahead of it
    task automatic send_pixel(input logic p, input logic sof);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        pixel          <= p;
        start_of_frame <= sof;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    // Hold the stream until every predicted point has come, then settle
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_points != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write both registers back to back; only while the stream is idle
    task automatic configure(input logic inner, input int width_val);
        cfg_valid <= 1'b1;
        cfg_index <= mbfn_pkg::REG_INNER_MODE;
        cfg_data  <= mbfn_pkg::CFG_DATA_W'(inner);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= mbfn_pkg::REG_ROW_WIDTH;
        cfg_data  <= mbfn_pkg::CFG_DATA_W'(width_val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = inner;
        cur_w    = (width_val < 2) ? 2 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : width_val);
    endtask

    // Send a frame of the given height plus two zero rows; a rectangle with
    // some flipped pixels or plain noise. A broken frame may stop mid-row or
    // shrink its width mid-row.
    task automatic send_frame(input int rows, input bit allow_break);
        int cut_row, cut_col, shrink_row, shrink_col;
        int x0, x1, y0, y1, flip_pct;
        bit use_rect, in_rect, p;
        cut_row    = -1;
        cut_col    = 0;
        shrink_row = -1;
        shrink_col = 0;
        if (allow_break && $urandom_range(7) == 0)
        begin
            cut_row = $urandom_range(rows + 1);
            cut_col = $urandom_range(cur_w - 1);
        end
        if (allow_break && cur_w >= 3 && $urandom_range(7) == 0)
        begin
            shrink_row = $urandom_range(rows + 1);
            shrink_col = $urandom_range(cur_w - 1, 2);
        end
        use_rect = $urandom_range(1);
        flip_pct = use_rect ? $urandom_range(8) : $urandom_range(100);
        x0 = $urandom_range(cur_w - 1);
        x1 = $urandom_range(cur_w - 1, x0);
        y0 = $urandom_range(rows - 1);
        y1 = $urandom_range(rows - 1, y0);

        for (int r = 0; r < rows + 2; r++)
        begin
            for (int c = 0; c < cur_w; c++)
            begin
                if (r == cut_row && c == cut_col)
                    return;
                if (r == shrink_row && c == shrink_col)
                begin
                    drain(SETTLE_CYCLES);
                    configure(cur_mode, $urandom_range(c, 2));
                    if (c >= cur_w)
                        break;
                end
                in_rect = use_rect && c >= x0 && c <= x1 && r >= y0 && r <= y1;
                p = (r < rows) && (in_rect ^ ($urandom_range(99) < flip_pct));
                send_pixel(p, r == 0 && c == 0);
            end
        end
    endtask

    initial
    begin
        logic [0:7]  tiny_frame;
        logic [0:11] narrow_rows;
        int          goal, frame_no, w_val;
        tiny_frame  = 8'b11_01_00_00;
        narrow_rows = 12'b111_111_000_000;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Outer mode, width below range: a stray pixel, then a frame
        // that restarts mid-row
        configure(1'b0, 1);
        send_pixel(1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_pixel(tiny_frame[i], i == 0);

        // Inner mode, width above range, then shrink it mid-row
        drain(SETTLE_CYCLES);
        configure(1'b1, 2047);
        for (int i = 0; i < 4; i++)
            send_pixel(1'b1, i == 0);
        drain(SETTLE_CYCLES);
        configure(1'b1, 3);
        for (int i = 0; i < 12; i++)
            send_pixel(narrow_rows[i], 1'b0);

        // One full-width row in outer mode and the head of the next,
        // without any idling
        drain(SETTLE_CYCLES);
        configure(1'b0, MAX_WIDTH);
        steady <= 1'b1;
        for (int i = 0; i < MAX_WIDTH + 4; i++)
            send_pixel(1'($urandom_range(1)), i == 0);
        steady <= 1'b0;

        // Back to a small width before the random frames
        drain(SETTLE_CYCLES);
        configure(1'($urandom_range(1)), $urandom_range(16, 2));

        // Random frames, mostly small, some broken
        goal     = TOTAL_PIXELS;
        frame_no = 0;
        while (pixels_sent < goal)
        begin
            if (frame_no % 8 == 4)
                drain(0);
            if ($urandom_range(2) == 0)
            begin
                drain(SETTLE_CYCLES);
                case ($urandom_range(9))
                    0:       w_val = $urandom_range(1);
                    1:       w_val = $urandom_range(48, 17);
                    default: w_val = $urandom_range(16, 2);
                endcase
                configure(1'($urandom_range(1)), w_val);
            end
            send_frame($urandom_range(6, 1), 1'b1);
            frame_no++;
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("mask_boundary_four_neighbor_test: done, clean");
        else
            $display("mask_boundary_four_neighbor_test: done, errors");
        $finish;
    end

endmodule
